@@ rtl/core/uart_acia_register_block_core_assert.svh @@
// Assertion macros for the serial register block core.
// Used by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef UART_ACIA_REGISTER_BLOCK_CORE_ASSERT_SVH
`define UART_ACIA_REGISTER_BLOCK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define UACIA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define UACIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UACIA_ASSERT(label, clk, rst_n, prop, msg)
`define UACIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/uacia_pkg.sv @@
// Shared types, codes and constants of the serial register block.
// No dependencies; every other file but the assertion header uses it by scoped names.
package uacia_pkg;

    localparam int BYTE_W     = 8;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE_PORT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BYTE_GAP  = 8'd1;

    localparam logic [BYTE_W-1:0] STATUS_TX_EMPTY  = 8'h02;
    localparam logic [BYTE_W-1:0] STATUS_RX_FULL   = 8'h01;
    localparam logic [BYTE_W-1:0] CTRL_RESET_MASK  = 8'h03;
    localparam logic [BYTE_W-1:0] CTRL_RXIE        = 8'h80;
    localparam logic [BYTE_W-1:0] CTRL_TXC_MASK    = 8'h60;
    localparam logic [BYTE_W-1:0] CTRL_TXC_RTS_OFF = 8'h40;

    localparam logic [BYTE_W-1:0] BASE_RESET = 8'hDE;
    localparam logic [TICK_W-1:0] GAP_RESET  = 16'd64;
    localparam logic [TICK_W-1:0] TICK_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] port;
        logic [BYTE_W-1:0] write_data;
        logic              script_valid;
        logic [BYTE_W-1:0] script_byte;
        logic              live_valid;
        logic [BYTE_W-1:0] live_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              read_hit;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              script_taken;
        logic              live_taken;
        logic              irq;
        logic              rts;
    } res_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] base_port;
        logic [TICK_W-1:0] byte_gap;
    } cfg_regs_t;

endpackage

@@ rtl/core/uacia_if.sv @@
// Channel interfaces: input items, result items and configuration writes.
// Depends on uacia_pkg for payload types and widths.
interface uacia_item_if;
    logic                valid;
    logic                ready;
    uacia_pkg::in_item_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface uacia_result_if;
    logic                 valid;
    logic                 ready;
    uacia_pkg::res_item_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface uacia_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [uacia_pkg::CFG_IDX_W-1:0]  index;
    logic [uacia_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/uacia_cfg.sv @@
// Configuration registers: base port and scripted byte gap.
// Depends on uacia_pkg and the configuration channel interface.
module uacia_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    uacia_cfg_if.sink            cfg,
    output uacia_pkg::cfg_regs_t regs
);

    logic [uacia_pkg::BYTE_W-1:0] base_port_reg;
    logic [uacia_pkg::TICK_W-1:0] byte_gap_reg;
    logic                         wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_port_reg <= uacia_pkg::BASE_RESET;
            byte_gap_reg  <= uacia_pkg::GAP_RESET;
        end
        else if (wr_en)
        begin
            if (cfg.index == uacia_pkg::CFG_IDX_BASE_PORT)
            begin
                base_port_reg <= cfg.data[uacia_pkg::BYTE_W-1:0];
            end
            else if (cfg.index == uacia_pkg::CFG_IDX_BYTE_GAP)
            begin
                byte_gap_reg <= cfg.data[uacia_pkg::TICK_W-1:0];
            end
        end
    end

    assign regs.base_port = base_port_reg;
    assign regs.byte_gap  = byte_gap_reg;

endmodule

@@ rtl/core/uacia_step.sv @@
// Receiver/transmitter state and the single-pass update for one item.
// Depends on uacia_pkg; the result is registered by the top level.
module uacia_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  uacia_pkg::in_item_t  item,
    input  uacia_pkg::cfg_regs_t regs,
    output uacia_pkg::res_item_t res
);

    logic [uacia_pkg::BYTE_W-1:0] rx_holding_reg, rx_holding_next;
    logic                         rx_full_reg, rx_full_next;
    logic                         rx_ie_reg, rx_ie_next;
    logic                         rts_reg, rts_next;
    logic [uacia_pkg::TICK_W-1:0] ticks_reg, ticks_next;

    logic [uacia_pkg::BYTE_W-1:0] data_port;
    logic [uacia_pkg::TICK_W-1:0] ticks_inc;
    logic                         status_hit;
    logic                         data_hit;
    logic                         script_ok;

    assign data_port  = regs.base_port + 8'd1;
    assign status_hit = (item.port == regs.base_port);
    assign data_hit   = (item.port == data_port);
    assign ticks_inc  = (ticks_reg != uacia_pkg::TICK_MAX) ? ticks_reg + 16'd1 : ticks_reg;
    assign script_ok  = !rx_full_reg && item.script_valid && rts_reg
                        && (ticks_inc >= regs.byte_gap);

    always_comb
    begin
        rx_holding_next = rx_holding_reg;
        rx_full_next    = rx_full_reg;
        rx_ie_next      = rx_ie_reg;
        rts_next        = rts_reg;
        ticks_next      = ticks_reg;
        res             = '0;
        unique case (item.opcode)
            uacia_pkg::OP_TICK:
            begin
                ticks_next = ticks_inc;
                if (script_ok)
                begin
                    rx_holding_next  = item.script_byte;
                    rx_full_next     = 1'b1;
                    res.script_taken = 1'b1;
                end
                else if (!rx_full_reg && item.live_valid && rts_reg)
                begin
                    rx_holding_next = item.live_byte;
                    rx_full_next    = 1'b1;
                    res.live_taken  = 1'b1;
                end
            end
            uacia_pkg::OP_READ:
            begin
                if (status_hit)
                begin
                    res.read_hit  = 1'b1;
                    res.read_data = uacia_pkg::STATUS_TX_EMPTY
                                    | (rx_full_reg ? uacia_pkg::STATUS_RX_FULL : 8'h00);
                end
                else if (data_hit)
                begin
                    res.read_hit  = 1'b1;
                    res.read_data = rx_holding_reg;
                    if (rx_full_reg)
                    begin
                        rx_full_next = 1'b0;
                        ticks_next   = '0;
                    end
                end
            end
            uacia_pkg::OP_WRITE:
            begin
                if (data_hit)
                begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = item.write_data;
                end
                else if (status_hit)
                begin
                    if ((item.write_data & uacia_pkg::CTRL_RESET_MASK)
                        == uacia_pkg::CTRL_RESET_MASK)
                    begin
                        rx_full_next = 1'b0;
                        rx_ie_next   = 1'b0;
                        rts_next     = 1'b0;
                    end
                    else
                    begin
                        rx_ie_next = |(item.write_data & uacia_pkg::CTRL_RXIE);
                        rts_next   = (item.write_data & uacia_pkg::CTRL_TXC_MASK)
                                     != uacia_pkg::CTRL_TXC_RTS_OFF;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.irq = rx_full_next && rx_ie_next;
        res.rts = rts_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_holding_reg <= '0;
            rx_full_reg    <= 1'b0;
            rx_ie_reg      <= 1'b0;
            rts_reg        <= 1'b1;
            ticks_reg      <= uacia_pkg::TICK_MAX;
        end
        else if (fire)
        begin
            rx_holding_reg <= rx_holding_next;
            rx_full_reg    <= rx_full_next;
            rx_ie_reg      <= rx_ie_next;
            rts_reg        <= rts_next;
            ticks_reg      <= ticks_next;
        end
    end

endmodule

@@ rtl/core/uart_acia_register_block_core.sv @@
// Top level of the serial register block: input register, update, result register.
// Depends on uacia_pkg, uacia_if, uacia_cfg, uacia_step and the assertion header.
//
// Takes one item (tick, port read or port write) per clock while the output side is
// not stalling, and returns one result per item. An accepted item is held in the
// input register, then updates the receive state and is captured in the result
// register, from which the result beat is offered; the beat completes when the
// output side is ready. That single update step is what allows one item per clock.
// Input is taken while a result waits, as long as the input register is free or
// moving. Configuration writes are taken at any time and are meant to be made while
// no item is in flight.
`include "uart_acia_register_block_core_assert.svh"

module uart_acia_register_block_core (
    input  logic        clk,
    input  logic        rst_n,
    uacia_item_if.sink  in_ch,
    uacia_result_if.source out_ch,
    uacia_cfg_if.sink   cfg_ch
);

    uacia_pkg::cfg_regs_t  regs;
    uacia_pkg::in_item_t   s1_item_reg;
    logic                  s1_valid_reg;
    uacia_pkg::res_item_t  res_reg;
    logic                  res_valid_reg;
    uacia_pkg::res_item_t  step_res;
    logic                  advance;
    logic                  in_fire;
    logic                  both_loaded;
    logic                  read_and_tx;

    assign advance     = s1_valid_reg && (!res_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_fire     = in_ch.valid && in_ch.ready;

    uacia_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .regs  (regs)
    );

    uacia_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (s1_item_reg),
        .regs  (regs),
        .res   (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_ch.item;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_ch.valid = res_valid_reg;
    assign out_ch.item  = res_reg;

    assign both_loaded = out_ch.item.script_taken && out_ch.item.live_taken;
    assign read_and_tx = out_ch.item.read_hit && out_ch.item.tx_valid;

    `UACIA_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, in_fire, s1_valid_reg, "beat lost")
    `UACIA_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, res_valid_reg, "result lost")
    `UACIA_ASSERT(a_single_load, clk, rst_n, !(out_ch.valid && both_loaded), "double load")
    `UACIA_ASSERT(a_read_or_tx, clk, rst_n, !(out_ch.valid && read_and_tx), "read with transmit")

endmodule
